// ----- hw/rtl/lmd_pkg.sv -----
`timescale 1ns / 1ps

package lmd_pkg;

    localparam int DEF_MAX_WIDTH   = 32;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int MAX_HEIGHT      = 1024;

    localparam int W_BITS        = 6;
    localparam int H_BITS        = 11;
    localparam int ROW_BITS      = 10;
    localparam int COL_BITS      = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int SLOT_BITS     = 2;

    localparam logic [W_BITS-1:0] RST_WIDTH  = 6'd5;
    localparam logic [H_BITS-1:0] RST_HEIGHT = 11'd5;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [SLOT_BITS-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_MID   = 2'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST  = 2'd2;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_slot;
        logic [SLOT_BITS-1:0] rd_slot;
    } store_ctrl_t;

    typedef struct packed {
        logic first;
        logic step;
        logic col_ok;
        logic up_ok;
        logic low_ok;
    } cmp_ctrl_t;

    function automatic logic [SLOT_BITS-1:0] slot_next(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] n;
        n = (s >= SLOT_LAST) ? SLOT_FIRST : s + SLOT_MID;
        return n;
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_prev(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] p;
        p = (s == SLOT_FIRST) ? SLOT_LAST : s - SLOT_MID;
        return p;
    endfunction

endpackage

// ----- hw/rtl/lmd_if.sv -----
`timescale 1ns / 1ps

interface lmd_sample_if #(
    parameter int SAMPLE_BITS = lmd_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface lmd_result_if #(
    parameter int SAMPLE_BITS = lmd_pkg::DEF_SAMPLE_BITS
);
    logic                            valid;
    logic                            ready;
    logic [lmd_pkg::ROW_BITS-1:0]    row_index;
    logic [lmd_pkg::COL_BITS-1:0]    column_index;
    logic signed [SAMPLE_BITS-1:0]   element_value;
    logic                            is_local_max;
    logic                            frame_done;
    logic                            run_last;

    modport source (
        output valid, output row_index, output column_index, output element_value,
        output is_local_max, output frame_done, output run_last, input ready
    );
    modport sink (
        input valid, input row_index, input column_index, input element_value,
        input is_local_max, input frame_done, input run_last, output ready
    );
endinterface

interface lmd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lmd_pkg::CFG_IDX_BITS-1:0]   index;
    logic [lmd_pkg::CFG_DATA_BITS-1:0]  write_data;

    modport source (output valid, output index, output write_data, input ready);
    modport sink (input valid, input index, input write_data, output ready);
endinterface

// ----- hw/rtl/lmd_line_stores.sv -----
`timescale 1ns / 1ps

module lmd_line_stores #(
    parameter int MAX_WIDTH   = lmd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = lmd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  lmd_pkg::store_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]         wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
    output logic signed [SAMPLE_BITS-1:0]         up_data,
    output logic signed [SAMPLE_BITS-1:0]         mid_data,
    output logic signed [SAMPLE_BITS-1:0]         low_data
);

    logic signed [SAMPLE_BITS-1:0] rd_data_reg [3];

    for (genvar k = 0; k < 3; k++) begin : g_store
        logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (ctrl.wr_en && (ctrl.wr_slot == lmd_pkg::SLOT_BITS'(k)))
            begin
                mem[wr_addr] <= wr_data;
            end
            rd_data_reg[k] <= mem[rd_addr];
        end
    end

    // The window rows rotate through the three stores as the frame advances.
    always_comb
    begin
        unique case (ctrl.rd_slot)
            lmd_pkg::SLOT_FIRST:
            begin
                up_data  = rd_data_reg[2];
                mid_data = rd_data_reg[0];
                low_data = rd_data_reg[1];
            end
            lmd_pkg::SLOT_MID:
            begin
                up_data  = rd_data_reg[0];
                mid_data = rd_data_reg[1];
                low_data = rd_data_reg[2];
            end
            default:
            begin
                up_data  = rd_data_reg[1];
                mid_data = rd_data_reg[2];
                low_data = rd_data_reg[0];
            end
        endcase
    end

endmodule

// ----- hw/rtl/lmd_window_cmp.sv -----
`timescale 1ns / 1ps

module lmd_window_cmp #(
    parameter int SAMPLE_BITS = lmd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lmd_pkg::cmp_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] up_data,
    input  logic signed [SAMPLE_BITS-1:0] mid_data,
    input  logic signed [SAMPLE_BITS-1:0] low_data,
    output logic signed [SAMPLE_BITS-1:0] center_value,
    output logic                          is_max
);

    logic signed [SAMPLE_BITS-1:0] center_reg;
    logic                          is_max_reg;
    logic                          is_max_next;
    logic signed [SAMPLE_BITS-1:0] ref_value;
    logic                          greater;

    // The center column is read first, so its middle row is the reference.
    assign ref_value = ctrl.first ? mid_data : center_reg;

    assign greater = ctrl.col_ok &&
                     ((ctrl.up_ok && (up_data > ref_value)) ||
                      (mid_data > ref_value) ||
                      (ctrl.low_ok && (low_data > ref_value)));

    always_comb
    begin
        is_max_next = is_max_reg;
        if (ctrl.step)
        begin
            is_max_next = ctrl.first ? !greater : (is_max_reg && !greater);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_max_reg <= 1'b0;
        end
        else
        begin
            is_max_reg <= is_max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.first)
        begin
            center_reg <= mid_data;
        end
    end

    assign center_value = center_reg;
    assign is_max       = is_max_reg;

endmodule

// ----- hw/rtl/local_maximum_detector_3x3.sv -----
`timescale 1ns / 1ps

// Marks every sample of a raster-ordered frame as a 3x3 local maximum or not, where
// neighbors outside the frame are ignored and ties count as maxima. A sample that
// decides nothing leaves the block idle. Each decision passes through a load step
// that reads the center column from the three line stores, three steps in which the
// single comparator checks one window column each (each store has one read port, so
// the window is read a column per cycle), and an output step with the result on the
// output, held until the consumer takes it. The last sample of a frame also decides
// its whole final row. No new sample is accepted while decisions are pending.
// A write to the width or height register restarts the frame; the line stores need
// no clearing.
module local_maximum_detector_3x3 #(
    parameter int MAX_WIDTH   = lmd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = lmd_pkg::DEF_SAMPLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    lmd_sample_if.sink   pixels,
    lmd_result_if.source results,
    lmd_cfg_if.sink      cfg
);

    localparam int CW = $clog2(MAX_WIDTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_CENTER = 6'b000100,
        S_LEFT   = 6'b001000,
        S_RIGHT  = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [lmd_pkg::W_BITS-1:0]          width_reg, width_next;
    logic [lmd_pkg::H_BITS-1:0]          height_reg, height_next;
    logic [CW-1:0]                       col_reg, col_next;
    logic [lmd_pkg::H_BITS-1:0]          row_reg, row_next;
    logic [lmd_pkg::SLOT_BITS-1:0]       slot_reg, slot_next;
    logic [CW-1:0]                       dec_col_reg, dec_col_next;
    logic [CW-1:0]                       end_col_reg, end_col_next;
    logic [lmd_pkg::H_BITS-1:0]          dec_row_reg, dec_row_next;
    logic [lmd_pkg::SLOT_BITS-1:0]       dec_slot_reg, dec_slot_next;
    logic                                fin_pending_reg, fin_pending_next;
    logic                                in_final_reg, in_final_next;

    logic [lmd_pkg::W_BITS-1:0]          eff_w;
    logic [lmd_pkg::H_BITS-1:0]          eff_h;
    logic [CW-1:0]                       last_col;
    logic [lmd_pkg::H_BITS-1:0]          last_row;
    logic                                col_last;
    logic                                row_last;
    logic                                has_prev;
    logic                                has_fin;
    logic                                left_ok;
    logic                                right_ok;
    logic                                last_decision;
    logic [CW-1:0]                       rd_addr;

    lmd_pkg::store_ctrl_t                store_ctrl;
    lmd_pkg::cmp_ctrl_t                  cmp_ctrl;
    logic signed [SAMPLE_BITS-1:0]       up_data;
    logic signed [SAMPLE_BITS-1:0]       mid_data;
    logic signed [SAMPLE_BITS-1:0]       low_data;
    logic signed [SAMPLE_BITS-1:0]       center_value;
    logic                                is_max;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = lmd_pkg::W_BITS'(1);
        end
        else if (width_reg > lmd_pkg::W_BITS'(MAX_WIDTH))
        begin
            eff_w = lmd_pkg::W_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end

        if (height_reg == '0)
        begin
            eff_h = lmd_pkg::H_BITS'(1);
        end
        else if (height_reg > lmd_pkg::H_BITS'(lmd_pkg::MAX_HEIGHT))
        begin
            eff_h = lmd_pkg::H_BITS'(lmd_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign last_col      = CW'(eff_w - lmd_pkg::W_BITS'(1));
    assign last_row      = eff_h - lmd_pkg::H_BITS'(1);
    assign col_last      = (col_reg == last_col);
    assign row_last      = (row_reg == last_row);
    assign has_prev      = (row_reg != '0) && ((col_reg != '0) || col_last);
    assign has_fin       = row_last && col_last;
    assign left_ok       = (dec_col_reg != '0);
    assign right_ok      = (dec_col_reg != last_col);
    assign last_decision = (dec_col_reg == end_col_reg) && !fin_pending_reg;

    always_comb
    begin
        state_next       = state_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        slot_next        = slot_reg;
        dec_col_next     = dec_col_reg;
        end_col_next     = end_col_reg;
        dec_row_next     = dec_row_reg;
        dec_slot_next    = dec_slot_reg;
        fin_pending_next = fin_pending_reg;
        in_final_next    = in_final_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pixels.valid)
                begin
                    if (has_fin)
                    begin
                        col_next  = '0;
                        row_next  = '0;
                        slot_next = lmd_pkg::SLOT_FIRST;
                    end
                    else if (col_last)
                    begin
                        col_next  = '0;
                        row_next  = row_reg + lmd_pkg::H_BITS'(1);
                        slot_next = lmd_pkg::slot_next(slot_reg);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end

                    if (has_prev)
                    begin
                        dec_col_next     = (col_reg != '0) ? col_reg - CW'(1) : col_reg;
                        end_col_next     = col_last ? col_reg : col_reg - CW'(1);
                        dec_row_next     = row_reg - lmd_pkg::H_BITS'(1);
                        dec_slot_next    = lmd_pkg::slot_prev(slot_reg);
                        fin_pending_next = has_fin;
                        in_final_next    = 1'b0;
                        state_next       = S_LOAD;
                    end
                    else if (has_fin)
                    begin
                        dec_col_next     = '0;
                        end_col_next     = last_col;
                        dec_row_next     = row_reg;
                        dec_slot_next    = slot_reg;
                        fin_pending_next = 1'b0;
                        in_final_next    = 1'b1;
                        state_next       = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_CENTER;
            end
            S_CENTER:
            begin
                state_next = S_LEFT;
            end
            S_LEFT:
            begin
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (results.ready)
                begin
                    if (dec_col_reg != end_col_reg)
                    begin
                        dec_col_next = dec_col_reg + CW'(1);
                        state_next   = S_LOAD;
                    end
                    else if (fin_pending_reg)
                    begin
                        dec_col_next     = '0;
                        end_col_next     = last_col;
                        dec_row_next     = dec_row_reg + lmd_pkg::H_BITS'(1);
                        dec_slot_next    = lmd_pkg::slot_next(dec_slot_reg);
                        fin_pending_next = 1'b0;
                        in_final_next    = 1'b1;
                        state_next       = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            unique case (cfg.index)
                lmd_pkg::REG_IMAGE_WIDTH:
                begin
                    width_next = cfg.write_data[lmd_pkg::W_BITS-1:0];
                    col_next   = '0;
                    row_next   = '0;
                    slot_next  = lmd_pkg::SLOT_FIRST;
                end
                lmd_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg.write_data[lmd_pkg::H_BITS-1:0];
                    col_next    = '0;
                    row_next    = '0;
                    slot_next   = lmd_pkg::SLOT_FIRST;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            width_reg       <= lmd_pkg::RST_WIDTH;
            height_reg      <= lmd_pkg::RST_HEIGHT;
            col_reg         <= '0;
            row_reg         <= '0;
            slot_reg        <= lmd_pkg::SLOT_FIRST;
            dec_col_reg     <= '0;
            end_col_reg     <= '0;
            dec_row_reg     <= '0;
            dec_slot_reg    <= lmd_pkg::SLOT_FIRST;
            fin_pending_reg <= 1'b0;
            in_final_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            slot_reg        <= slot_next;
            dec_col_reg     <= dec_col_next;
            end_col_reg     <= end_col_next;
            dec_row_reg     <= dec_row_next;
            dec_slot_reg    <= dec_slot_next;
            fin_pending_reg <= fin_pending_next;
            in_final_reg    <= in_final_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_CENTER: rd_addr = left_ok ? dec_col_reg - CW'(1) : dec_col_reg;
            S_LEFT:   rd_addr = right_ok ? dec_col_reg + CW'(1) : dec_col_reg;
            default:  rd_addr = dec_col_reg;
        endcase
    end

    always_comb
    begin
        store_ctrl.wr_en   = (state_reg == S_IDLE) && pixels.valid;
        store_ctrl.wr_slot = slot_reg;
        store_ctrl.rd_slot = dec_slot_reg;

        cmp_ctrl.first  = (state_reg == S_CENTER);
        cmp_ctrl.step   = (state_reg == S_CENTER) || (state_reg == S_LEFT) ||
                          (state_reg == S_RIGHT);
        cmp_ctrl.col_ok = (state_reg == S_LEFT) ? left_ok :
                          (state_reg == S_RIGHT) ? right_ok : 1'b1;
        cmp_ctrl.up_ok  = (dec_row_reg != '0);
        cmp_ctrl.low_ok = (dec_row_reg != last_row);
    end

    lmd_line_stores #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_stores (
        .clk      (clk),
        .ctrl     (store_ctrl),
        .wr_addr  (col_reg),
        .wr_data  (pixels.sample_value),
        .rd_addr  (rd_addr),
        .up_data  (up_data),
        .mid_data (mid_data),
        .low_data (low_data)
    );

    lmd_window_cmp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window_cmp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (cmp_ctrl),
        .up_data      (up_data),
        .mid_data     (mid_data),
        .low_data     (low_data),
        .center_value (center_value),
        .is_max       (is_max)
    );

    assign pixels.ready          = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign results.valid         = (state_reg == S_OUT);
    assign results.row_index     = lmd_pkg::ROW_BITS'(dec_row_reg);
    assign results.column_index  = lmd_pkg::COL_BITS'(dec_col_reg);
    assign results.element_value = center_value;
    assign results.is_local_max  = is_max;
    assign results.run_last      = last_decision;
    assign results.frame_done    = last_decision && in_final_reg;

    a_no_input_while_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        results.valid |-> !pixels.ready
    ) else $error("sample accepted while a result is pending");

    a_frame_done_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && results.frame_done) |-> results.run_last
    ) else $error("frame end flagged on a result that is not the last of its sample");

    a_idle_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.run_last) |=> pixels.ready
    ) else $error("block still busy after the last result of a sample");

    a_column_in_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        col_reg <= last_col
    ) else $error("column counter beyond the frame width");

    a_decision_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((dec_col_reg <= end_col_reg) &&
                                   (end_col_reg <= last_col) &&
                                   (dec_slot_reg <= lmd_pkg::SLOT_LAST))
    ) else $error("decision cursor out of range");

endmodule
